// ===== rtl/gpd_pkg.sv =====
`default_nettype none
package gpd_pkg;

  // The state arrays are four deep and the pad field is two bits wide.
  localparam int unsigned DEPTH             = 4;
  localparam int unsigned PAD_W             = 2;
  localparam int unsigned DEFAULT_PAD_COUNT = 4;
  localparam int unsigned TIMEOUT_W         = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd250;

  localparam logic OP_REPORT    = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam logic KIND_CHANGE  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } gpd_state_t;

  typedef struct packed {
    logic take_report;
    logic take_tick;
    logic emit_release;
  } gpd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pending;
  } gpd_status_t;

endpackage
`default_nettype wire

// ===== rtl/gpd_if.sv =====
`default_nettype none
interface gpd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] pad_number;
  logic [7:0] direction_byte;
  logic [7:0] button_byte;

  modport source (output valid, output operation, output pad_number,
                  output direction_byte, output button_byte, input ready);
  modport sink   (input valid, input operation, input pad_number,
                  input direction_byte, input button_byte, output ready);
endinterface

interface gpd_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        pad;
  logic              kind;
  logic signed [1:0] axis_x;
  logic signed [1:0] axis_y;
  logic [7:0]        button_mask;
  logic              last_of_run;

  modport source (output valid, output pad, output kind, output axis_x,
                  output axis_y, output button_mask, output last_of_run,
                  input ready);
  modport sink   (input valid, input pad, input kind, input axis_x,
                  input axis_y, input button_mask, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/gpd_ctrl.sv =====
`default_nettype none
module gpd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_operation,
  output logic                      in_ready,
  input  wire gpd_pkg::gpd_status_t status,
  output gpd_pkg::gpd_cmd_t         cmd
);

  gpd_pkg::gpd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      gpd_pkg::ST_IDLE: begin
        // A report may load the output register at once, so wait for room.
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          if (in_operation == gpd_pkg::OP_TICK) begin
            cmd.take_tick = 1'b1;
            state_nxt     = gpd_pkg::ST_SCAN;
          end else begin
            cmd.take_report = 1'b1;
          end
        end
      end
      gpd_pkg::ST_SCAN: begin
        if (!status.pending) begin
          state_nxt = gpd_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit_release = 1'b1;
        end
      end
      default: state_nxt = gpd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/gpd_datapath.sv =====
`default_nettype none
module gpd_datapath #(
  parameter int unsigned PAD_COUNT = gpd_pkg::DEFAULT_PAD_COUNT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_write_en,
  input  wire logic [gpd_pkg::TIMEOUT_W-1:0]     cfg_write_data,
  input  wire logic [7:0]                        in_pad_number,
  input  wire logic [7:0]                        in_direction_byte,
  input  wire logic [7:0]                        in_button_byte,
  input  wire gpd_pkg::gpd_cmd_t                 cmd,
  output gpd_pkg::gpd_status_t                   status,
  gpd_out_if.source                              out_chan
);

  localparam int unsigned DEPTH  = gpd_pkg::DEPTH;
  localparam int unsigned PAD_W  = gpd_pkg::PAD_W;
  localparam int unsigned TW     = gpd_pkg::TIMEOUT_W;
  localparam int unsigned SERVED = (PAD_COUNT < DEPTH) ? PAD_COUNT : DEPTH;

  logic [TW-1:0]    timeout_r;
  logic [15:0]      stored_r [DEPTH];
  logic [TW-1:0]    count_r  [DEPTH];
  logic [DEPTH-1:0] armed_r;
  logic [DEPTH-1:0] expire_r;

  logic              out_valid_r;
  logic [PAD_W-1:0]  out_pad_r;
  logic              out_kind_r;
  logic signed [1:0] out_ax_r;
  logic signed [1:0] out_ay_r;
  logic [7:0]        out_mask_r;
  logic              out_last_r;

  logic              out_free;
  logic              pad_ok;
  logic [PAD_W-1:0]  pad_idx;
  logic [15:0]       report;
  logic              changed;
  logic [TW-1:0]     timeout_eff;
  logic signed [1:0] dec_ax;
  logic signed [1:0] dec_ay;
  logic [7:0]        dec_mask;
  logic [DEPTH-1:0]  tick_expire;
  logic [PAD_W-1:0]  sel_idx;
  logic              sel_found;
  logic [DEPTH-1:0]  expire_rest;

  assign out_free = !out_valid_r || out_chan.ready;
  assign status.out_free = out_free;
  assign status.pending  = |expire_r;

  assign pad_ok      = {24'd0, in_pad_number} < 32'(SERVED);
  assign pad_idx     = in_pad_number[PAD_W-1:0];
  assign report      = {in_button_byte, in_direction_byte};
  assign changed     = report != stored_r[pad_idx];
  assign timeout_eff = (timeout_r == '0) ? TW'(1) : timeout_r;

  // Down wins over up and right wins over left.
  always_comb begin
    dec_ay = 2'sb00;
    dec_ax = 2'sb00;
    if (in_direction_byte[1]) begin
      dec_ay = 2'sb01;
    end else if (in_direction_byte[0]) begin
      dec_ay = 2'sb11;
    end
    if (in_direction_byte[3]) begin
      dec_ax = 2'sb01;
    end else if (in_direction_byte[2]) begin
      dec_ax = 2'sb11;
    end
    dec_mask = {in_button_byte[7:2], in_direction_byte[5:4]};
  end

  // An armed countdown at one or zero runs out on this tick.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      tick_expire[i] = armed_r[i] && (count_r[i] <= TW'(1));
    end
  end

  always_comb begin
    sel_idx   = '0;
    sel_found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (expire_r[i] && !sel_found) begin
        sel_idx   = PAD_W'(i);
        sel_found = 1'b1;
      end
    end
    expire_rest = expire_r & ~(DEPTH'(1) << sel_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= gpd_pkg::TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_r <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= '0;
      expire_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        stored_r[i] <= '0;
        count_r[i]  <= '0;
      end
    end else begin
      if (cmd.take_report && pad_ok) begin
        count_r[pad_idx] <= timeout_eff;
        armed_r[pad_idx] <= 1'b1;
        if (changed) begin
          stored_r[pad_idx] <= report;
        end
      end
      if (cmd.take_tick) begin
        expire_r <= tick_expire;
        for (int i = 0; i < DEPTH; i++) begin
          if (tick_expire[i]) begin
            armed_r[i]  <= 1'b0;
            stored_r[i] <= '0;
            count_r[i]  <= '0;
          end else if (armed_r[i]) begin
            count_r[i] <= count_r[i] - TW'(1);
          end
        end
      end
      if (cmd.emit_release) begin
        expire_r <= expire_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_release || (cmd.take_report && pad_ok && changed)) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_release) begin
      out_pad_r  <= sel_idx;
      out_kind_r <= gpd_pkg::KIND_RELEASE;
      out_ax_r   <= 2'sb00;
      out_ay_r   <= 2'sb00;
      out_mask_r <= '0;
      out_last_r <= expire_rest == '0;
    end else if (cmd.take_report && pad_ok && changed) begin
      out_pad_r  <= pad_idx;
      out_kind_r <= gpd_pkg::KIND_CHANGE;
      out_ax_r   <= dec_ax;
      out_ay_r   <= dec_ay;
      out_mask_r <= dec_mask;
      out_last_r <= 1'b1;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pad         = out_pad_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.axis_x      = out_ax_r;
  assign out_chan.axis_y      = out_ay_r;
  assign out_chan.button_mask = out_mask_r;
  assign out_chan.last_of_run = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/gamepad_report_decoder.sv =====
// A report's result is registered into the output register when the request is accepted.
// A tick first updates all countdowns; the controller then walks the expiry mask, emitting
// one release per expired pad (up to four) as the output has room, then returns to idle.
// Throughput: one report per cycle when the sink keeps up; a scan holds off requests.
// Reset (rst_n, synchronous, active low) clears all pad state and sets the timeout to 250.
`default_nettype none
module gamepad_report_decoder #(
  parameter int unsigned PAD_COUNT = gpd_pkg::DEFAULT_PAD_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_write_en,
  input  wire logic [gpd_pkg::TIMEOUT_W-1:0] cfg_write_data,
  gpd_in_if.sink                             in_chan,
  gpd_out_if.source                          out_chan
);

  gpd_pkg::gpd_cmd_t    cmd;
  gpd_pkg::gpd_status_t status;
  logic                 in_ready;

  assign in_chan.ready = in_ready;

  gpd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  gpd_datapath #(
    .PAD_COUNT (PAD_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_pad_number     (in_chan.pad_number),
    .in_direction_byte (in_chan.direction_byte),
    .in_button_byte    (in_chan.button_byte),
    .cmd               (cmd),
    .status            (status),
    .out_chan          (out_chan)
  );

endmodule
`default_nettype wire

// ===== dv/tb_gamepad_report_decoder.sv =====
module tb_gamepad_report_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import gpd_pkg::*;

  localparam int unsigned SERVED = (DEFAULT_PAD_COUNT < DEPTH) ? DEFAULT_PAD_COUNT : DEPTH;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned PHASE_ITEMS     = 20;
  localparam int unsigned N_DIRECTED      = 23;

  typedef struct packed {
    logic       operation;
    logic [7:0] pad_number;
    logic [7:0] direction_byte;
    logic [7:0] button_byte;
  } pad_req_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic              kind;
    logic signed [1:0] axis_x;
    logic signed [1:0] axis_y;
    logic [7:0]        button_mask;
    logic              last_of_run;
  } pad_event_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    pad_req_t   req;
    logic [TIMEOUT_W-1:0] timeout;
    logic       typed;
    pad_event_t typed_event;
  } step_row_t;

  localparam pad_event_t NO_EVENT = '0;

  // Rows with a typed event are checked against that event; the rest go
  // through the decoder model.
  localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_REQ, '{OP_REPORT, 8'd0, 8'h00, 8'h00}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd0, 8'hFF, 8'hFF}, 16'd0, 1'b1,
      '{2'd0, KIND_CHANGE, 2'sd1, 2'sd1, 8'hFF, 1'b1}},
    '{ROW_REQ, '{OP_REPORT, 8'd0, 8'hFF, 8'hFF}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd1, 8'h01, 8'h00}, 16'd0, 1'b1,
      '{2'd1, KIND_CHANGE, 2'sd0, -2'sd1, 8'h00, 1'b1}},
    '{ROW_REQ, '{OP_REPORT, 8'd2, 8'h04, 8'h03}, 16'd0, 1'b1,
      '{2'd2, KIND_CHANGE, -2'sd1, 2'sd0, 8'h00, 1'b1}},
    '{ROW_REQ, '{OP_REPORT, 8'd3, 8'hC0, 8'h00}, 16'd0, 1'b1,
      '{2'd3, KIND_CHANGE, 2'sd0, 2'sd0, 8'h00, 1'b1}},
    '{ROW_REQ, '{OP_REPORT, 8'd4, 8'h0F, 8'hF0}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd255, 8'hAA, 8'h55}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd3, 8'h30, 8'h00}, 16'd0, 1'b1,
      '{2'd3, KIND_CHANGE, 2'sd0, 2'sd0, 8'h03, 1'b1}},
    '{ROW_REQ, '{OP_REPORT, 8'd1, 8'h0A, 8'h30}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_TICK, 8'd0, 8'h00, 8'h00}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_CFG, '{OP_REPORT, 8'd0, 8'h00, 8'h00}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd0, 8'hFF, 8'hFF}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd1, 8'h05, 8'h40}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd2, 8'h04, 8'h03}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd3, 8'h30, 8'h00}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_TICK, 8'd0, 8'h00, 8'h00}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_TICK, 8'd0, 8'h00, 8'h00}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_REPORT, 8'd2, 8'h00, 8'h00}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_TICK, 8'd0, 8'h00, 8'h00}, 16'd0, 1'b1,
      '{2'd2, KIND_RELEASE, 2'sd0, 2'sd0, 8'h00, 1'b1}},
    '{ROW_REQ, '{OP_REPORT, 8'd0, 8'hFF, 8'hFF}, 16'd0, 1'b1,
      '{2'd0, KIND_CHANGE, 2'sd1, 2'sd1, 8'hFF, 1'b1}},
    '{ROW_REQ, '{OP_REPORT, 8'd0, 8'hC3, 8'hFC}, 16'd0, 1'b0, NO_EVENT},
    '{ROW_REQ, '{OP_TICK, 8'd0, 8'h00, 8'h00}, 16'd0, 1'b0, NO_EVENT}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_write_en;
  logic [TIMEOUT_W-1:0] cfg_write_data;

  gpd_in_if  in_chan();
  gpd_out_if out_chan();

  gamepad_report_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_chan        (in_chan),
    .out_chan       (out_chan)
  );

  // Decoder model state.
  logic [TIMEOUT_W-1:0] release_ticks;
  logic [15:0]          pad_last_report [DEPTH];
  logic [15:0]          pad_ticks_left  [DEPTH];
  logic                 pad_armed       [DEPTH];

  pad_event_t  expected_pad_events[$];
  int unsigned mismatch_count;
  int unsigned send_calm;
  int unsigned sink_calm;
  bit          hold_off_pending;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void decode_request(input pad_req_t r, output pad_event_t evs[$]);
    int unsigned       p;
    logic [15:0]       rep;
    pad_event_t        ev;
    evs = {};
    if (r.operation == OP_REPORT) begin
      if (r.pad_number >= SERVED) return;
      p = 32'(r.pad_number);
      pad_ticks_left[p] = (release_ticks == '0) ? 16'd1 : release_ticks;
      pad_armed[p] = 1'b1;
      rep = {r.button_byte, r.direction_byte};
      if (rep == pad_last_report[p]) return;
      pad_last_report[p] = rep;
      ev = '0;
      ev.pad = p[1:0];
      ev.kind = KIND_CHANGE;
      // Down wins over up and right over left.
      ev.axis_y = r.direction_byte[1] ? 2'sd1 : (r.direction_byte[0] ? -2'sd1 : 2'sd0);
      ev.axis_x = r.direction_byte[3] ? 2'sd1 : (r.direction_byte[2] ? -2'sd1 : 2'sd0);
      ev.button_mask = {r.button_byte[7:2], r.direction_byte[5:4]};
      ev.last_of_run = 1'b1;
      evs.push_back(ev);
    end else begin
      for (p = 0; p < SERVED; p++) begin
        if (!pad_armed[p]) continue;
        if (pad_ticks_left[p] != 0) pad_ticks_left[p]--;
        if (pad_ticks_left[p] == 0) begin
          pad_armed[p] = 1'b0;
          pad_last_report[p] = '0;
          ev = '0;
          ev.pad = p[1:0];
          ev.kind = KIND_RELEASE;
          evs.push_back(ev);
        end
      end
      if (evs.size() > 0) evs[evs.size()-1].last_of_run = 1'b1;
    end
  endfunction

  // Mostly random gaps, with occasional stretches of back-to-back traffic.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(5, 15);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic pad_req_t random_request();
    pad_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.operation      = OP_REPORT;
    r.pad_number     = 8'($urandom_range(0, SERVED - 1));
    r.direction_byte = 8'($urandom);
    r.button_byte    = 8'($urandom);
    if (pick < 35) begin
      r.operation = OP_TICK;
    end else if (pick < 45) begin
      r.pad_number = 8'($urandom_range(SERVED, 255));
    end else if (pick < 60) begin
      // Repeat of what the pad already holds, which only restarts its countdown.
      {r.button_byte, r.direction_byte} = pad_last_report[r.pad_number[PAD_W-1:0]];
    end else if (pick < 65) begin
      r.direction_byte = '0;
      r.button_byte    = '0;
    end
    return r;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_request(input pad_req_t r, input logic typed, input pad_event_t typed_ev);
    int unsigned gap;
    pad_event_t  evs[$];
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.operation      <= r.operation;
    in_chan.pad_number     <= r.pad_number;
    in_chan.direction_byte <= r.direction_byte;
    in_chan.button_byte    <= r.button_byte;
    do @(posedge clk); while (!in_chan.ready);
    decode_request(r, evs);
    if (typed) expected_pad_events.push_back(typed_ev);
    else foreach (evs[i]) expected_pad_events.push_back(evs[i]);
  endtask

  task automatic wait_for_drain(input int unsigned extra);
    in_chan.valid <= 1'b0;
    while (expected_pad_events.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_release_timeout(input logic [TIMEOUT_W-1:0] value);
    // A tick that expires nothing may still be scanning when the queue empties.
    wait_for_drain(SETTLE_CYCLES);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    release_ticks = value;
  endtask

  initial begin : result_sink
    int unsigned gap;
    pad_event_t  want;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end else begin
        gap = draw_gap(sink_calm);
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      if (expected_pad_events.size() == 0) begin
        $error("event with nothing expected: pad %0d kind %0d", out_chan.pad, out_chan.kind);
        mismatch_count++;
      end else begin
        want = expected_pad_events.pop_front();
        compare_field("pad", want.pad, out_chan.pad);
        compare_field("kind", want.kind, out_chan.kind);
        compare_field("axis_x", want.axis_x, out_chan.axis_x);
        compare_field("axis_y", want.axis_y, out_chan.axis_y);
        compare_field("button_mask", want.button_mask, out_chan.button_mask);
        compare_field("last_of_run", want.last_of_run, out_chan.last_of_run);
      end
    end
  end

  initial begin : stimulus
    logic [TIMEOUT_W-1:0] phase_timeouts [5];
    rst_n                  <= 1'b0;
    cfg_write_en           <= 1'b0;
    cfg_write_data         <= '0;
    in_chan.valid          <= 1'b0;
    in_chan.operation      <= OP_REPORT;
    in_chan.pad_number     <= '0;
    in_chan.direction_byte <= '0;
    in_chan.button_byte    <= '0;
    mismatch_count   = 0;
    send_calm        = 0;
    sink_calm        = 0;
    hold_off_pending = 1'b0;
    release_ticks    = TIMEOUT_RESET;
    for (int p = 0; p < DEPTH; p++) begin
      pad_last_report[p] = '0;
      pad_ticks_left[p]  = '0;
      pad_armed[p]       = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) set_release_timeout(DIRECTED_ROWS[i].timeout);
      else send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].typed_event);
    end

    phase_timeouts[0] = 16'd1;
    phase_timeouts[1] = 16'd2;
    phase_timeouts[2] = 16'hFFFF;
    phase_timeouts[3] = 16'd3;
    phase_timeouts[4] = TIMEOUT_W'($urandom_range(4, 8));
    foreach (phase_timeouts[ph]) begin
      set_release_timeout(phase_timeouts[ph]);
      // A long receiver stall early on, so the block backs up into its input.
      if (ph == 0) hold_off_pending = 1'b1;
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, NO_EVENT);
    end

    wait_for_drain(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
